// ----- sv/f32_to_fp8_fnuz_saturating_convert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the binary32 to FP8 FNUZ converter
// Shorthand for clocked properties checked under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef F32_TO_FP8_FNUZ_SATURATING_CONVERT_MACROS_SVH
`define F32_TO_FP8_FNUZ_SATURATING_CONVERT_MACROS_SVH

// Same-cycle implication
`define F8CV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define F8CV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/f8cv_pkg.sv -----
// ----------------------------------------------------------------------------
// f8cv_pkg
// Format constants and stage payload types of the FP8 FNUZ converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package f8cv_pkg;

  // Target format select
  localparam logic MODE_E4M3 = 1'b0;
  localparam logic MODE_E5M2 = 1'b1;

  // Binary32 exponent field codes
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [7:0] EXP_ZERO    = 8'h00;

  // Exponent below which the result is built as an output subnormal
  localparam logic [7:0] SUB_LIMIT_E4M3 = 8'd121;
  localparam logic [7:0] SUB_LIMIT_E5M2 = 8'd113;
  // Exponent that the shift aligns a subnormal to
  localparam logic [7:0] SUB_BASE_E4M3  = 8'd120;
  localparam logic [7:0] SUB_BASE_E5M2  = 8'd112;

  // Half bias of each format and the binary32 bias
  localparam logic [8:0] HALF_BIAS_E4M3 = 9'd8;
  localparam logic [8:0] HALF_BIAS_E5M2 = 9'd16;
  localparam logic [8:0] F32_BIAS       = 9'd127;
  // Exponent code of an aligned subnormal before rounding
  localparam logic [7:0] E_NORM_SUB     = 8'd0;

  // Significand bits dropped below the output mantissa
  localparam logic [7:0]  DROP_E4M3      = 8'd20;
  localparam logic [7:0]  DROP_E5M2      = 8'd21;
  localparam logic [24:0] DROP_MASK_E4M3 = 25'h00F_FFFF;
  localparam logic [24:0] DROP_MASK_E5M2 = 25'h01F_FFFF;

  // Largest exponent code before saturation
  localparam logic [8:0] EMAX_E4M3 = 9'd15;
  localparam logic [8:0] EMAX_E5M2 = 9'd31;

  // Result codes
  localparam logic [7:0] NAN_CODE  = 8'h80;
  localparam logic [7:0] ZERO_CODE = 8'h00;
  localparam logic [6:0] SAT_MAG   = 7'h7F;

  // Decoded item after the first stage
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        zero;
    logic        mode;
    logic [6:0]  diff;
    logic [23:0] sig;
    logic [7:0]  e_norm;
  } f8cv_dec_t;

  // Aligned item after the second stage
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        zero;
    logic        mode;
    logic [23:0] m0;
    logic        at_mid;
    logic [7:0]  e_norm;
  } f8cv_align_t;

endpackage

// ----- sv/f8cv_round_pack.sv -----
// ----------------------------------------------------------------------------
// f8cv_round_pack
// Round an aligned significand to nearest even and pack the FP8 code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module f8cv_round_pack
  import f8cv_pkg::*;
(
  input  f8cv_align_t aln,
  output logic [7:0]  code
);

  logic        is_e5m2;
  logic [24:0] drop_mask;
  logic        lsb;
  logic [24:0] inc;
  logic [24:0] low;
  logic [24:0] rounded;
  logic        carry;
  logic        sub_up;
  logic [8:0]  e_out;
  logic [23:0] m_out;
  logic [8:0]  emax;
  logic        under;

  // Round at the dropped bits; a tie looks at the kept lsb
  always_comb begin
    is_e5m2   = (aln.mode == MODE_E5M2);
    drop_mask = is_e5m2 ? DROP_MASK_E5M2 : DROP_MASK_E4M3;
    lsb       = is_e5m2 ? aln.m0[21] : aln.m0[20];
    inc       = aln.at_mid ? (25'(lsb) + drop_mask) : 25'd0;
    low       = (25'(aln.m0) + inc) & drop_mask;
    rounded   = low + 25'(aln.m0);
    carry     = rounded[24];
    // A subnormal that rounds up reaches the smallest normal exponent
    sub_up    = (aln.e_norm == E_NORM_SUB) && rounded[23];
    e_out     = sub_up ? 9'd1 : 9'(aln.e_norm) + 9'(carry);
    m_out     = (!sub_up && carry) ? rounded[24:1] : rounded[23:0];
    emax      = is_e5m2 ? EMAX_E5M2 : EMAX_E4M3;
    // Nothing left after rounding gives positive zero
    under     = (e_out == 9'd0) &&
                (is_e5m2 ? (m_out[22:21] == 2'd0) : (m_out[22:20] == 3'd0));
  end

  // Pick special codes first, then saturate, then flush underflow to zero, then pack
  always_comb begin
    priority if (aln.nan) begin
      code = NAN_CODE;
    end else if (aln.zero) begin
      code = ZERO_CODE;
    end else if (e_out > emax) begin
      code = {aln.sign, SAT_MAG};
    end else if (under) begin
      code = ZERO_CODE;
    end else if (is_e5m2) begin
      code = {aln.sign, e_out[4:0], m_out[22:21]};
    end else begin
      code = {aln.sign, e_out[3:0], m_out[22:20]};
    end
  end

endmodule

// ----- sv/f32_to_fp8_fnuz_saturating_convert.sv -----
// ----------------------------------------------------------------------------
// f32_to_fp8_fnuz_saturating_convert
// Converts a binary32 bit pattern to an FP8 FNUZ code, E4M3 (mode 0) or
// E5M2 (mode 1). Infinity and NaN give 0x80, zero and denormal inputs give
// 0x00, finite values round to nearest even and saturate to sign|0x7F.
// The converter takes one item per cycle while in_stall is low and passes
// each result through its three register stages (decode, align, round and
// pack). A stall on the output holds the full pipeline; empty stages keep
// filling, so in_stall rises only when all three stages hold an item and
// out_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "f32_to_fp8_fnuz_saturating_convert_macros.svh"

module f32_to_fp8_fnuz_saturating_convert
  import f8cv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_single_bits,
  input  logic        in_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_fp8_code
);

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  f8cv_dec_t   dec_nxt, dec_r;
  f8cv_align_t aln_nxt, aln_r;
  logic [7:0]  code_nxt, code_r;
  logic [7:0]  ex;
  logic [8:0]  e_norm_w;
  logic [7:0]  shift_top;
  logic [24:0] tie_mask;
  logic [23:0] tie_bit;

  // Advance a stage when it is empty or the next one moves
  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // Stage 1: classify the exponent and find the subnormal shift
  always_comb begin
    ex             = in_single_bits[30:23];
    dec_nxt.sign   = in_single_bits[31];
    dec_nxt.nan    = (ex == EXP_SPECIAL);
    dec_nxt.zero   = (ex == EXP_ZERO);
    dec_nxt.mode   = in_mode;
    dec_nxt.sig    = {1'b1, in_single_bits[22:0]};
    if (in_mode == MODE_E5M2) begin
      dec_nxt.diff = (ex < SUB_LIMIT_E5M2) ? 7'(SUB_BASE_E5M2 - ex) : 7'd0;
      e_norm_w     = 9'(ex) + HALF_BIAS_E5M2 - F32_BIAS;
    end else begin
      dec_nxt.diff = (ex < SUB_LIMIT_E4M3) ? 7'(SUB_BASE_E4M3 - ex) : 7'd0;
      e_norm_w     = 9'(ex) + HALF_BIAS_E4M3 - F32_BIAS;
    end
    dec_nxt.e_norm = (dec_nxt.diff == 7'd0) ? e_norm_w[7:0] : E_NORM_SUB;
  end

  // Stage 2: align the significand and detect an exact tie
  always_comb begin
    shift_top      = 8'(dec_r.diff) +
                     ((dec_r.mode == MODE_E5M2) ? DROP_E5M2 : DROP_E4M3);
    tie_mask       = (25'd1 << shift_top) - 25'd1;
    tie_bit        = 24'd1 << (shift_top - 8'd1);
    aln_nxt.sign   = dec_r.sign;
    aln_nxt.nan    = dec_r.nan;
    aln_nxt.zero   = dec_r.zero;
    aln_nxt.mode   = dec_r.mode;
    aln_nxt.m0     = dec_r.sig >> dec_r.diff;
    aln_nxt.at_mid = (shift_top <= 8'd24) && ((dec_r.sig & tie_mask[23:0]) == tie_bit);
    aln_nxt.e_norm = dec_r.e_norm;
  end

  // Stage 3: round and pack
  f8cv_round_pack u_round_pack (
    .aln  (aln_r),
    .code (code_nxt)
  );

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Hold payload while a stage is stalled
  always_ff @(posedge clk) begin
    if (rdy1) begin
      dec_r <= dec_nxt;
    end
    if (rdy2) begin
      aln_r <= aln_nxt;
    end
    if (rdy3) begin
      code_r <= code_nxt;
    end
  end

  assign out_valid    = v3_r;
  assign out_fp8_code = code_r;

  // Checks on pipeline control and special codes
  `F8CV_ASSERT_IMPL(a_stall_only_full, in_stall, v1_r && v2_r && v3_r && out_stall,
                    "input stalled with a free stage")
  `F8CV_ASSERT_NEXT(a_nan_code, v2_r && aln_r.nan && rdy3, v3_r && (code_r == NAN_CODE),
                    "special input did not give the NaN code")
  `F8CV_ASSERT_NEXT(a_zero_code, v2_r && aln_r.zero && rdy3, v3_r && (code_r == ZERO_CODE),
                    "zero exponent did not give zero")

endmodule
